>>> rtl/wbe_pkg.sv
// Package for the WLAN backoff engine: event codes, register indexes,
// reset values, shared types and the contention window helpers.
// No dependencies.
`default_nettype none

package wbe_pkg;

    // Default width of the window and slot counter
    localparam int WINDOW_BITS_DEF = 10;

    // Fixed field widths
    localparam int CW_W     = 10;
    localparam int TICK_W   = 16;
    localparam int FUNC_W   = 2;
    localparam int ATT_W    = 5;
    localparam int RND_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Event codes carried in the func field
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_IDLE    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BUSY    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AIFS_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CW_MIN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CW_MAX     = 2'd3;

    // Register reset values
    localparam logic [TICK_W-1:0] SLOT_TICKS_RST = 16'd9;
    localparam logic [TICK_W-1:0] AIFS_TICKS_RST = 16'd34;
    localparam logic [CW_W-1:0]   CW_MIN_RST     = 10'd15;
    localparam logic [CW_W-1:0]   CW_MAX_RST     = 10'd1023;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [TICK_W-1:0] slot_ticks;
        logic [TICK_W-1:0] aifs_ticks;
        logic [CW_W-1:0]   cw_min;
        logic [CW_W-1:0]   cw_max;
    } t_cfg;

    // Single-bit control state of the engine
    typedef struct packed {
        logic running;
        logic in_aifs;
        logic finished;
        logic tx_pending;
        logic busy;
    } t_flags;

    // Single-bit result flags of one word
    typedef struct packed {
        logic grant;
        logic req_err;
    } t_rflags;

    function automatic logic [CW_W-1:0] f_min(
        input logic [CW_W-1:0] a,
        input logic [CW_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    // Window for an attempt: min((cw_min+1)*2^(n-1)-1, cw_max), n=0 as n=1
    function automatic logic [CW_W-1:0] f_window_for(
        input logic [CW_W-1:0]  cw_min,
        input logic [CW_W-1:0]  cw_max,
        input logic [ATT_W-1:0] attempt
    );
        logic [ATT_W-1:0] shamt;
        logic [21:0]      scaled;
        logic [21:0]      cw;
        shamt  = (attempt == '0) ? '0 : attempt - ATT_W'(1);
        scaled = 22'({1'b0, cw_min} + 11'd1) << shamt[3:0];
        cw     = scaled - 22'd1;
        if (shamt > ATT_W'(10)) begin
            return cw_max;
        end
        return (cw > 22'(cw_max)) ? cw_max : cw[CW_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/wbe_core.sv
// Next-state and result logic of the backoff engine for one word.
// Purely combinational; depends on wbe_pkg.
`default_nettype none

module wbe_core #(
    parameter int WINDOW_BITS = wbe_pkg::WINDOW_BITS_DEF
) (
    input  wbe_pkg::t_cfg                      i_cfg,
    input  wbe_pkg::t_flags                    i_flags,
    input  logic [WINDOW_BITS-1:0]             i_window,
    input  logic [WINDOW_BITS-1:0]             i_slot,
    input  logic [wbe_pkg::TICK_W-1:0]         i_elapsed,
    input  logic [wbe_pkg::FUNC_W-1:0]         i_func,
    input  logic [wbe_pkg::ATT_W-1:0]          i_attempt,
    input  logic [wbe_pkg::RND_W-1:0]          i_rnd,
    output wbe_pkg::t_flags                    o_flags,
    output logic [WINDOW_BITS-1:0]             o_window,
    output logic [WINDOW_BITS-1:0]             o_slot,
    output logic [wbe_pkg::TICK_W-1:0]         o_elapsed,
    output wbe_pkg::t_rflags                   o_rflags
);

    localparam int PROD_W = wbe_pkg::RND_W + WINDOW_BITS + 1;

    logic [wbe_pkg::TICK_W-1:0] dur;
    logic [wbe_pkg::TICK_W-1:0] elapsed_inc;
    logic [WINDOW_BITS-1:0]     min_window;
    logic [WINDOW_BITS-1:0]     draw_window;
    logic [WINDOW_BITS:0]       win_plus;
    logic [PROD_W-1:0]          product;
    logic [WINDOW_BITS-1:0]     draw;
    logic [WINDOW_BITS-1:0]     req_window;

    // Timer duration of the current phase, zero acts as one tick
    always_comb begin
        dur = i_flags.in_aifs ? i_cfg.aifs_ticks : i_cfg.slot_ticks;
        if (dur == '0) begin
            dur = wbe_pkg::TICK_W'(1);
        end
    end

    // Saturating tick count
    assign elapsed_inc = (i_elapsed != '1) ? i_elapsed + wbe_pkg::TICK_W'(1) : i_elapsed;

    // Fresh slot draw: (rnd * (window + 1)) >> 16
    assign min_window  = WINDOW_BITS'(wbe_pkg::f_min(i_cfg.cw_min, i_cfg.cw_max));
    assign draw_window = i_flags.tx_pending ? i_window : min_window;
    assign win_plus    = {1'b0, draw_window} + (WINDOW_BITS+1)'(1);
    assign product     = PROD_W'(i_rnd) * PROD_W'(win_plus);
    assign draw        = product[wbe_pkg::RND_W +: WINDOW_BITS];

    assign req_window  = WINDOW_BITS'(wbe_pkg::f_window_for(i_cfg.cw_min, i_cfg.cw_max,
                                                            i_attempt));

    // Apply one event word
    always_comb begin
        o_flags  = i_flags;
        o_window = i_window;
        o_slot   = i_slot;
        o_elapsed = i_elapsed;
        o_rflags = '0;
        case (i_func)
            wbe_pkg::FUNC_TICK: begin
                if (i_flags.running) begin
                    o_elapsed = elapsed_inc;
                    if (elapsed_inc >= dur) begin
                        // Timer expired: leave AIFS or count down one slot
                        if (i_flags.in_aifs) begin
                            o_flags.in_aifs = 1'b0;
                            if (i_slot == '0) begin
                                o_window = draw_window;
                                o_slot   = draw;
                            end
                        end else if (i_slot != '0) begin
                            o_slot = i_slot - WINDOW_BITS'(1);
                        end
                        o_elapsed = '0;
                        if (o_slot == '0) begin
                            o_flags.running  = 1'b0;
                            o_flags.finished = 1'b1;
                            if (i_flags.tx_pending) begin
                                o_flags.tx_pending = 1'b0;
                                o_flags.finished   = 1'b0;
                                o_rflags.grant     = 1'b1;
                            end
                        end
                    end
                end
            end
            wbe_pkg::FUNC_IDLE: begin
                // Restart the AIFS wait
                o_flags.busy     = 1'b0;
                o_flags.finished = 1'b0;
                o_flags.in_aifs  = 1'b1;
                o_flags.running  = 1'b1;
                o_elapsed        = '0;
            end
            wbe_pkg::FUNC_BUSY: begin
                // Freeze the countdown
                o_flags.busy    = 1'b1;
                o_flags.running = 1'b0;
                o_elapsed       = '0;
            end
            wbe_pkg::FUNC_REQUEST: begin
                if (i_flags.tx_pending) begin
                    o_rflags.req_err = 1'b1;
                end else begin
                    o_flags.tx_pending = 1'b1;
                    o_window           = req_window;
                    // Post-backoff already done on an idle medium: grant now
                    if (i_flags.finished && !i_flags.busy) begin
                        o_flags.tx_pending = 1'b0;
                        o_flags.finished   = 1'b0;
                        o_rflags.grant     = 1'b1;
                    end
                end
            end
            default: begin
                o_rflags = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/wlan_backoff_engine.sv
// WLAN backoff engine top level: config registers, state and output register.
// Depends on wbe_pkg and wbe_core.
// The result of each accepted word is registered in the output register.
// Throughput: one word per cycle when not stalled; all work is one pass through wbe_core.
// Input ready drops only while the output register holds an untaken result.
// Reset (synchronous, active low): defaults in config, AIFS wait running, no result held.
`default_nettype none

module wlan_backoff_engine #(
    parameter int WINDOW_BITS = wbe_pkg::WINDOW_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wbe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wbe_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    // event channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [wbe_pkg::FUNC_W-1:0]        i_func,
    input  logic [wbe_pkg::ATT_W-1:0]         i_attempt_number,
    input  logic [wbe_pkg::RND_W-1:0]         i_random_fraction,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_grant,
    output logic                              o_request_error,
    output logic [wbe_pkg::CW_W-1:0]          o_slot_counter,
    output logic [wbe_pkg::CW_W-1:0]          o_window_now,
    output logic                              o_post_backoff_done
);

    wbe_pkg::t_cfg              r_cfg;
    wbe_pkg::t_flags            r_flags, n_flags;
    logic [WINDOW_BITS-1:0]     r_window, n_window;
    logic [WINDOW_BITS-1:0]     r_slot, n_slot;
    logic [wbe_pkg::TICK_W-1:0] r_elapsed, n_elapsed;
    wbe_pkg::t_rflags           n_rflags;

    logic                       r_out_valid;
    logic                       r_grant;
    logic                       r_req_err;
    logic [wbe_pkg::CW_W-1:0]   r_slot_out;
    logic [wbe_pkg::CW_W-1:0]   r_window_out;
    logic                       r_done;
    logic                       accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign accept      = i_valid && o_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slot_ticks <= wbe_pkg::SLOT_TICKS_RST;
            r_cfg.aifs_ticks <= wbe_pkg::AIFS_TICKS_RST;
            r_cfg.cw_min     <= wbe_pkg::CW_MIN_RST;
            r_cfg.cw_max     <= wbe_pkg::CW_MAX_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wbe_pkg::CFG_SLOT_TICKS: r_cfg.slot_ticks <= i_cfg_data;
                wbe_pkg::CFG_AIFS_TICKS: r_cfg.aifs_ticks <= i_cfg_data;
                wbe_pkg::CFG_CW_MIN:     r_cfg.cw_min <= i_cfg_data[wbe_pkg::CW_W-1:0];
                wbe_pkg::CFG_CW_MAX:     r_cfg.cw_max <= i_cfg_data[wbe_pkg::CW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    wbe_core #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_core (
        .i_cfg     (r_cfg),
        .i_flags   (r_flags),
        .i_window  (r_window),
        .i_slot    (r_slot),
        .i_elapsed (r_elapsed),
        .i_func    (i_func),
        .i_attempt (i_attempt_number),
        .i_rnd     (i_random_fraction),
        .o_flags   (n_flags),
        .o_window  (n_window),
        .o_slot    (n_slot),
        .o_elapsed (n_elapsed),
        .o_rflags  (n_rflags)
    );

    // Engine state: advance on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags.running    <= 1'b1;
            r_flags.in_aifs    <= 1'b1;
            r_flags.finished   <= 1'b0;
            r_flags.tx_pending <= 1'b0;
            r_flags.busy       <= 1'b0;
            r_window           <= WINDOW_BITS'(wbe_pkg::CW_MIN_RST);
            r_slot             <= '0;
            r_elapsed          <= '0;
        end else if (accept) begin
            r_flags   <= n_flags;
            r_window  <= n_window;
            r_slot    <= n_slot;
            r_elapsed <= n_elapsed;
        end
    end

    // Output valid: set on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_grant      <= n_rflags.grant;
            r_req_err    <= n_rflags.req_err;
            r_slot_out   <= wbe_pkg::CW_W'(n_slot);
            r_window_out <= wbe_pkg::CW_W'(n_window);
            r_done       <= n_flags.finished;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_grant             = r_grant;
    assign o_request_error     = r_req_err;
    assign o_slot_counter      = r_slot_out;
    assign o_window_now        = r_window_out;
    assign o_post_backoff_done = r_done;

    // A grant and a rejected request never come from the same word
    a_grant_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_grant && o_request_error))
        else $error("grant and request_error both set");

    // A grant consumes the finished backoff
    a_grant_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_grant) |-> !o_post_backoff_done)
        else $error("post_backoff_done set with grant");

    // Post-backoff can only be done with the counter at zero
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.finished |-> (r_slot == '0))
        else $error("finished with nonzero slot count");

    // A pending request never survives an expiry to zero
    a_grant_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_rflags.grant) |=> !r_flags.tx_pending)
        else $error("request still pending after grant");

endmodule

`default_nettype wire

>>> bench/wbe_checker.sv
// Checker for the WLAN backoff engine: follows the config, event and result channels,
// predicts every result word and compares it with what the engine returns.
// Depends on wbe_pkg for field widths, event codes and register indexes.
`default_nettype none

module wbe_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration channel
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [wbe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wbe_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // event channel
    input  logic                          i_evt_valid,
    input  logic                          i_evt_ready,
    input  logic [wbe_pkg::FUNC_W-1:0]    i_evt_func,
    input  logic [wbe_pkg::ATT_W-1:0]     i_evt_attempt,
    input  logic [wbe_pkg::RND_W-1:0]     i_evt_random,
    // result channel
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic                          i_res_grant,
    input  logic                          i_res_error,
    input  logic [wbe_pkg::CW_W-1:0]      i_res_slots,
    input  logic [wbe_pkg::CW_W-1:0]      i_res_window,
    input  logic                          i_res_pb_done,
    // status toward the bench top
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                     grant;
        logic                     req_err;
        logic [wbe_pkg::CW_W-1:0] slots;
        logic [wbe_pkg::CW_W-1:0] window;
        logic                     pb_done;
    } t_backoff_word;

    // Result words predicted but not yet returned, oldest first
    t_backoff_word backoff_words_q[$];
    int            fail_count = 0;

    // Register copy
    logic [wbe_pkg::TICK_W-1:0] cf_slot;
    logic [wbe_pkg::TICK_W-1:0] cf_aifs;
    logic [wbe_pkg::CW_W-1:0]   cf_cwmin;
    logic [wbe_pkg::CW_W-1:0]   cf_cwmax;

    // Engine state copy
    logic [wbe_pkg::CW_W-1:0]   cnt_slots;
    logic [wbe_pkg::CW_W-1:0]   cur_window;
    logic [wbe_pkg::TICK_W-1:0] tick_count;
    logic                       timer_on;
    logic                       aifs_phase;
    logic                       pb_done;
    logic                       req_waiting;
    logic                       chan_busy;

    function automatic logic [wbe_pkg::CW_W-1:0] lesser(
        input logic [wbe_pkg::CW_W-1:0] a,
        input logic [wbe_pkg::CW_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    // Double the window per retry, stop as soon as it passes the ceiling
    function automatic logic [wbe_pkg::CW_W-1:0] attempt_window(
        input logic [wbe_pkg::ATT_W-1:0] att
    );
        int unsigned cw;
        cw = cf_cwmin;
        for (int unsigned i = 1; i < att; i++) begin
            cw = cw * 2 + 1;
            if (cw > cf_cwmax) break;
        end
        return (cw < cf_cwmax) ? cw[wbe_pkg::CW_W-1:0] : cf_cwmax;
    endfunction

    task automatic reset_engine();
        cf_slot     = wbe_pkg::SLOT_TICKS_RST;
        cf_aifs     = wbe_pkg::AIFS_TICKS_RST;
        cf_cwmin    = wbe_pkg::CW_MIN_RST;
        cf_cwmax    = wbe_pkg::CW_MAX_RST;
        cnt_slots   = '0;
        cur_window  = wbe_pkg::CW_MIN_RST;
        tick_count  = '0;
        timer_on    = 1'b1;
        aifs_phase  = 1'b1;
        pb_done     = 1'b0;
        req_waiting = 1'b0;
        chan_busy   = 1'b0;
    endtask

    // End of an AIFS wait or of one slot
    task automatic finish_wait(input logic [wbe_pkg::RND_W-1:0] rnd, output logic granted);
        int unsigned prod;
        granted = 1'b0;
        if (aifs_phase) begin
            aifs_phase = 1'b0;
            if (cnt_slots == 0) begin
                if (!req_waiting) cur_window = lesser(cf_cwmin, cf_cwmax);
                prod      = 32'(rnd) * (32'(cur_window) + 32'd1);
                cnt_slots = prod[25:16];
            end
        end else if (cnt_slots != 0) begin
            cnt_slots = cnt_slots - 1'b1;
        end
        tick_count = '0;
        if (cnt_slots == 0) begin
            timer_on = 1'b0;
            pb_done  = 1'b1;
            if (req_waiting) begin
                req_waiting = 1'b0;
                pb_done     = 1'b0;
                granted     = 1'b1;
            end
        end
    endtask

    // Advance the engine copy by one event word and form the result word
    task automatic apply_event(
        input  logic [wbe_pkg::FUNC_W-1:0] func,
        input  logic [wbe_pkg::ATT_W-1:0]  att,
        input  logic [wbe_pkg::RND_W-1:0]  rnd,
        output t_backoff_word              w
    );
        logic [wbe_pkg::TICK_W-1:0] dur;
        logic                       granted;
        logic                       err;
        granted = 1'b0;
        err     = 1'b0;
        case (func)
            wbe_pkg::FUNC_TICK: begin
                if (timer_on) begin
                    dur = aifs_phase ? cf_aifs : cf_slot;
                    if (dur == 0) dur = 16'd1;
                    if (tick_count != 16'hFFFF) tick_count = tick_count + 1'b1;
                    if (tick_count >= dur) finish_wait(rnd, granted);
                end
            end
            wbe_pkg::FUNC_IDLE: begin
                chan_busy  = 1'b0;
                pb_done    = 1'b0;
                aifs_phase = 1'b1;
                timer_on   = 1'b1;
                tick_count = '0;
            end
            wbe_pkg::FUNC_BUSY: begin
                chan_busy  = 1'b1;
                timer_on   = 1'b0;
                tick_count = '0;
            end
            default: begin
                if (req_waiting) begin
                    err = 1'b1;
                end else begin
                    req_waiting = 1'b1;
                    cur_window  = attempt_window(att);
                    if (pb_done && !chan_busy) begin
                        req_waiting = 1'b0;
                        pb_done     = 1'b0;
                        granted     = 1'b1;
                    end
                end
            end
        endcase
        w.grant   = granted;
        w.req_err = err;
        w.slots   = cnt_slots;
        w.window  = cur_window;
        w.pb_done = pb_done;
    endtask

    task automatic check_field(input string name, input logic [wbe_pkg::CW_W-1:0] want,
                               input logic [wbe_pkg::CW_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Sample all channels at the rising edge; retire results before adding new ones
    always @(posedge i_clk) begin
        t_backoff_word want;
        if (!i_rst_n) begin
            reset_engine();
            backoff_words_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (backoff_words_q.size() == 0) begin
                    fail_count++;
                    $display({"%0t ns: result word expected none, got grant=%0d err=%0d",
                              " slots=%0d window=%0d pb_done=%0d"},
                             $time, i_res_grant, i_res_error, i_res_slots, i_res_window,
                             i_res_pb_done);
                end else begin
                    want = backoff_words_q.pop_front();
                    check_field("grant", wbe_pkg::CW_W'(want.grant),
                                wbe_pkg::CW_W'(i_res_grant));
                    check_field("request_error", wbe_pkg::CW_W'(want.req_err),
                                wbe_pkg::CW_W'(i_res_error));
                    check_field("slot_counter", want.slots, i_res_slots);
                    check_field("window_now", want.window, i_res_window);
                    check_field("post_backoff_done", wbe_pkg::CW_W'(want.pb_done),
                                wbe_pkg::CW_W'(i_res_pb_done));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    wbe_pkg::CFG_SLOT_TICKS: cf_slot  = i_cfg_data;
                    wbe_pkg::CFG_AIFS_TICKS: cf_aifs  = i_cfg_data;
                    wbe_pkg::CFG_CW_MIN:     cf_cwmin = i_cfg_data[wbe_pkg::CW_W-1:0];
                    default:                 cf_cwmax = i_cfg_data[wbe_pkg::CW_W-1:0];
                endcase
            end
            if (i_evt_valid && i_evt_ready) begin
                apply_event(i_evt_func, i_evt_attempt, i_evt_random, want);
                backoff_words_q.push_back(want);
            end
        end
        o_pending    = backoff_words_q.size();
        o_fail_count = fail_count;
    end

endmodule

`default_nettype wire

>>> bench/tb.sv
// Bench top for the WLAN backoff engine: clock, reset, event and config stimulus,
// result-side back-pressure and the verdict. Depends on wbe_pkg, wlan_backoff_engine
// and wbe_checker.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 60;

    typedef enum int {PACE_FREE, PACE_SENDER_IDLE, PACE_RECV_STALL, PACE_BOTH} t_pace;

    logic                          i_clk;
    logic                          i_rst_n           = 1'b0;
    logic                          i_cfg_valid       = 1'b0;
    logic                          o_cfg_ready;
    logic [wbe_pkg::CFG_IDX_W-1:0] i_cfg_index       = '0;
    logic [wbe_pkg::CFG_DAT_W-1:0] i_cfg_data        = '0;
    logic                          i_valid           = 1'b0;
    logic                          o_ready;
    logic [wbe_pkg::FUNC_W-1:0]    i_func            = '0;
    logic [wbe_pkg::ATT_W-1:0]     i_attempt_number  = '0;
    logic [wbe_pkg::RND_W-1:0]     i_random_fraction = '0;
    logic                          o_valid;
    logic                          i_ready           = 1'b1;
    logic                          o_grant;
    logic                          o_request_error;
    logic [wbe_pkg::CW_W-1:0]      o_slot_counter;
    logic [wbe_pkg::CW_W-1:0]      o_window_now;
    logic                          o_post_backoff_done;

    t_pace pace      = PACE_FREE;
    bit    hold_req  = 1'b0;
    int    hold_left = 0;
    int    cycles    = 0;
    int    fails;
    int    pending;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    wlan_backoff_engine u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_func              (i_func),
        .i_attempt_number    (i_attempt_number),
        .i_random_fraction   (i_random_fraction),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_grant             (o_grant),
        .o_request_error     (o_request_error),
        .o_slot_counter      (o_slot_counter),
        .o_window_now        (o_window_now),
        .o_post_backoff_done (o_post_backoff_done)
    );

    wbe_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_evt_valid   (i_valid),
        .i_evt_ready   (o_ready),
        .i_evt_func    (i_func),
        .i_evt_attempt (i_attempt_number),
        .i_evt_random  (i_random_fraction),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_res_grant   (o_grant),
        .i_res_error   (o_request_error),
        .i_res_slots   (o_slot_counter),
        .i_res_window  (o_window_now),
        .i_res_pb_done (o_post_backoff_done),
        .o_fail_count  (fails),
        .o_pending     (pending)
    );

    // Result-side ready: random stalls per pace, or a long hold-off on request
    initial begin
        int stall_pct;
        forever begin
            @(negedge i_clk);
            stall_pct = (pace == PACE_RECV_STALL) ? 74 : (pace == PACE_BOTH) ? 15 : 0;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready = 1'b0;
            end else begin
                i_ready = ($urandom_range(0, 99) < stall_pct) ? 1'b0 : 1'b1;
            end
        end
    end

    // Watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one event word, with idle gaps per pace, and hold it until taken
    task automatic put_word(input logic [wbe_pkg::FUNC_W-1:0] func,
                            input logic [wbe_pkg::ATT_W-1:0] att,
                            input logic [wbe_pkg::RND_W-1:0] rnd);
        int gap_pct;
        gap_pct = (pace == PACE_SENDER_IDLE) ? 74 : (pace == PACE_BOTH) ? 15 : 0;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid           = 1'b1;
        i_func            = func;
        i_attempt_number  = att;
        i_random_fraction = rnd;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic write_reg(input logic [wbe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wbe_pkg::CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Stop offering and wait for every outstanding result word
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic set_regs(input int slot, input int aifs, input int cwmin, input int cwmax);
        drain();
        write_reg(wbe_pkg::CFG_SLOT_TICKS, wbe_pkg::CFG_DAT_W'(slot));
        write_reg(wbe_pkg::CFG_AIFS_TICKS, wbe_pkg::CFG_DAT_W'(aifs));
        write_reg(wbe_pkg::CFG_CW_MIN, wbe_pkg::CFG_DAT_W'(cwmin));
        write_reg(wbe_pkg::CFG_CW_MAX, wbe_pkg::CFG_DAT_W'(cwmax));
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly ticks, with idle/busy events and requests mixed in
    task automatic random_word();
        int                         r;
        logic [wbe_pkg::FUNC_W-1:0] func;
        logic [wbe_pkg::ATT_W-1:0]  att;
        r = $urandom_range(0, 99);
        if (r < 66)      func = wbe_pkg::FUNC_TICK;
        else if (r < 74) func = wbe_pkg::FUNC_IDLE;
        else if (r < 80) func = wbe_pkg::FUNC_BUSY;
        else             func = wbe_pkg::FUNC_REQUEST;
        if ($urandom_range(0, 99) < 85) att = wbe_pkg::ATT_W'($urandom_range(1, 16));
        else                            att = wbe_pkg::ATT_W'($urandom_range(0, 31));
        put_word(func, att, wbe_pkg::RND_W'($urandom));
    endtask

    task automatic run_phase(input int slot, input int aifs, input int cwmin, input int cwmax,
                             input t_pace mode, input int count, input int hold_at);
        set_regs(slot, aifs, cwmin, cwmax);
        pace = mode;
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_req = 1'b1;
            random_word();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset registers: attempt zero, second request flagged, busy stops the timer
        put_word(wbe_pkg::FUNC_REQUEST, 5'd0, 16'h0000);
        put_word(wbe_pkg::FUNC_REQUEST, 5'd16, 16'hFFFF);
        put_word(wbe_pkg::FUNC_BUSY, 5'd1, 16'h0000);
        put_word(wbe_pkg::FUNC_TICK, 5'd1, 16'h8000);
        put_word(wbe_pkg::FUNC_IDLE, 5'd1, 16'h0000);
        put_word(wbe_pkg::FUNC_TICK, 5'd1, 16'h0000);

        // Zero durations and zero window: the shortened AIFS expires on the next tick
        set_regs(0, 0, 0, 0);
        put_word(wbe_pkg::FUNC_TICK, 5'd1, 16'hFFFF);
        put_word(wbe_pkg::FUNC_TICK, 5'd1, 16'h0000);
        put_word(wbe_pkg::FUNC_IDLE, 5'd1, 16'h0000);
        put_word(wbe_pkg::FUNC_TICK, 5'd1, 16'h1234);
        // Request while one is still pending: flagged as a request error
        put_word(wbe_pkg::FUNC_REQUEST, 5'd5, 16'h1234);
        put_word(wbe_pkg::FUNC_IDLE, 5'd1, 16'h0000);
        put_word(wbe_pkg::FUNC_TICK, 5'd1, 16'h0000);
        // Busy medium, then another request while one is pending (flagged), then idle
        put_word(wbe_pkg::FUNC_BUSY, 5'd1, 16'h0000);
        put_word(wbe_pkg::FUNC_REQUEST, 5'd2, 16'h0000);
        put_word(wbe_pkg::FUNC_IDLE, 5'd1, 16'h0000);
        put_word(wbe_pkg::FUNC_TICK, 5'd1, 16'hFFFF);

        // Widest window settings and the largest random fraction
        set_regs(1, 1, 1023, 1023);
        put_word(wbe_pkg::FUNC_REQUEST, 5'd31, 16'h0000);
        put_word(wbe_pkg::FUNC_IDLE, 5'd1, 16'h0000);
        put_word(wbe_pkg::FUNC_TICK, 5'd1, 16'hFFFF);
        put_word(wbe_pkg::FUNC_TICK, 5'd1, 16'h0000);
        put_word(wbe_pkg::FUNC_TICK, 5'd1, 16'h0000);
        put_word(wbe_pkg::FUNC_REQUEST, 5'd3, 16'h0000);
        put_word(wbe_pkg::FUNC_IDLE, 5'd1, 16'h0000);

        // Random phases across settings and pacing
        run_phase(9, 34, 15, 1023, PACE_FREE, 250, -1);
        run_phase(1, 2, 3, 31, PACE_SENDER_IDLE, 250, -1);
        run_phase(2, 3, 0, 7, PACE_RECV_STALL, 250, 100);
        run_phase($urandom_range(1, 4), $urandom_range(1, 6), 7, 1023, PACE_BOTH, 250, -1);
        run_phase(65535, 65535, 1023, 1023, PACE_FREE, 100, -1);
        run_phase(0, 0, 1023, 5, PACE_RECV_STALL, 250, 40);
        run_phase($urandom_range(1, 5), $urandom_range(1, 8), $urandom_range(0, 63),
                  $urandom_range(0, 1023), PACE_BOTH, 250, -1);
        run_phase(1, 1, 1, 3, PACE_FREE, 250, -1);

        drain();
        repeat (5) @(posedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
